[rtl/ttf_pkg.sv]
// ----------------------------------------------------------------------------
// Term format parser package
// Shared types, tag constants and codes of the term format stream parser.
// ----------------------------------------------------------------------------
package ttf_pkg;

  localparam int unsigned LengthWidth = 32;

  localparam logic [7:0] MagicByte     = 8'd131;
  localparam logic [7:0] TagSmallInt   = 8'd97;
  localparam logic [7:0] TagInt        = 8'd98;
  localparam logic [7:0] TagSmallTuple = 8'd104;
  localparam logic [7:0] TagNil        = 8'd106;
  localparam logic [7:0] TagString     = 8'd107;
  localparam logic [7:0] TagList       = 8'd108;
  localparam logic [7:0] TagBinary     = 8'd109;
  localparam logic [7:0] KeyLimitReset = 8'd33 - 8'd1;

  typedef enum logic [4:0] {
    PhMagic, PhTuple, PhArity, PhKeyTag, PhKeyLen, PhKeyData,
    PhValTag, PhVSmall, PhVInt, PhBinLen, PhBinData, PhStrLen,
    PhStrData, PhListLen, PhLTag, PhLElem, PhLNil
  } phase_e;

  typedef enum logic [2:0] {
    EvKey  = 3'd0,
    EvInt  = 3'd1,
    EvElem = 3'd2,
    EvBlob = 3'd3,
    EvEnd  = 3'd4,
    EvErr  = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    KindNil  = 2'd0,
    KindInt  = 2'd1,
    KindList = 2'd2,
    KindBin  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ErrNone  = 3'd0,
    ErrMagic = 3'd1,
    ErrTuple = 3'd2,
    ErrArity = 3'd3,
    ErrTag   = 3'd4,
    ErrZero  = 3'd5
  } err_e;

  typedef struct packed {
    event_e             event_res;
    logic signed [31:0] data;
    logic [31:0]        position;
    logic [1:0]         arity;
    kind_e              value_kind;
    err_e               error_code;
    logic               ends_message;
  } result_t;

endpackage

[rtl/ttf_parser.sv]
// ----------------------------------------------------------------------------
// Term format parser step logic
// Holds the parse state and the key limit register and turns one accepted
// byte into the next state and at most one result.
// ----------------------------------------------------------------------------
module ttf_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic             accept_i,
  input  logic [7:0]       byte_i,
  output logic             res_valid_o,
  output ttf_pkg::result_t res_o
);

  localparam int unsigned LenW = ttf_pkg::LengthWidth;

  ttf_pkg::phase_e phase_q, phase_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [31:0]     word_q, word_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic [31:0]     elem_q, elem_d;
  logic [1:0]      arity_q, arity_d;
  ttf_pkg::kind_e  kind_q, kind_d;
  logic            wide_q, wide_d;
  logic [7:0]      key_limit_q;

  logic [2:0]      cnt_inc;
  logic [31:0]     word_shift;
  logic [LenW-1:0] rem_dec;
  logic            rem_zero;
  logic [LenW-1:0] len_word;
  logic [LenW-1:0] len_str;
  logic            shown;
  logic            emit;
  ttf_pkg::event_e ev;
  logic [31:0]     ev_data;
  logic [31:0]     ev_pos;
  ttf_pkg::err_e   ev_err;
  logic            ev_ends;

  assign cnt_inc    = cnt_q + 3'd1;
  assign word_shift = {word_q[23:0], byte_i};
  assign rem_dec    = rem_q - LenW'(1);
  assign rem_zero   = (rem_dec == '0);
  assign len_word   = word_shift[LenW-1:0];
  assign len_str    = LenW'(word_shift[15:0]);
  assign shown      = (elem_q < {24'd0, key_limit_q});

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    word_d  = word_q;
    rem_d   = rem_q;
    elem_d  = elem_q;
    arity_d = arity_q;
    kind_d  = kind_q;
    wide_d  = wide_q;
    emit    = 1'b0;
    ev      = ttf_pkg::EvEnd;
    ev_data = 32'd0;
    ev_pos  = 32'd0;
    ev_err  = ttf_pkg::ErrNone;
    ev_ends = 1'b0;
    unique case (phase_q)
      ttf_pkg::PhMagic: begin
        arity_d = 2'd0;
        kind_d  = ttf_pkg::KindNil;
        if (byte_i != ttf_pkg::MagicByte) begin
          emit = 1'b1; ev = ttf_pkg::EvErr; ev_err = ttf_pkg::ErrMagic; ev_ends = 1'b1;
        end else begin
          phase_d = ttf_pkg::PhTuple;
        end
      end
      ttf_pkg::PhTuple: begin
        if (byte_i != ttf_pkg::TagSmallTuple) begin
          emit = 1'b1; ev = ttf_pkg::EvErr; ev_err = ttf_pkg::ErrTuple; ev_ends = 1'b1;
        end else begin
          phase_d = ttf_pkg::PhArity;
        end
      end
      ttf_pkg::PhArity: begin
        if (byte_i > 8'd2) begin
          emit = 1'b1; ev = ttf_pkg::EvErr; ev_err = ttf_pkg::ErrArity; ev_ends = 1'b1;
        end else begin
          arity_d = byte_i[1:0];
          if (byte_i == 8'd0) begin
            emit = 1'b1; ev_ends = 1'b1;
          end else begin
            phase_d = ttf_pkg::PhKeyTag;
          end
        end
      end
      ttf_pkg::PhKeyTag: begin
        if (byte_i != ttf_pkg::TagBinary) begin
          emit = 1'b1; ev = ttf_pkg::EvErr; ev_err = ttf_pkg::ErrTag; ev_ends = 1'b1;
        end else begin
          cnt_d = 3'd0; word_d = 32'd0; phase_d = ttf_pkg::PhKeyLen;
        end
      end
      ttf_pkg::PhKeyLen: begin
        word_d = word_shift;
        if (cnt_inc >= 3'd4) begin
          cnt_d  = 3'd0;
          rem_d  = len_word;
          elem_d = 32'd0;
          if (len_word != '0) begin
            phase_d = ttf_pkg::PhKeyData;
          end else if (arity_q == 2'd1) begin
            emit = 1'b1; ev_ends = 1'b1;
          end else begin
            phase_d = ttf_pkg::PhValTag;
          end
        end else begin
          cnt_d = cnt_inc;
        end
      end
      ttf_pkg::PhKeyData: begin
        elem_d  = elem_q + 32'd1;
        rem_d   = rem_dec;
        ev_data = {24'd0, byte_i};
        ev_pos  = elem_q;
        ev      = ttf_pkg::EvKey;
        emit    = shown;
        if (rem_zero) begin
          if (arity_q == 2'd1) begin
            emit    = 1'b1;
            ev_ends = 1'b1;
            if (!shown) begin
              ev = ttf_pkg::EvEnd; ev_data = 32'd0; ev_pos = 32'd0;
            end
          end else begin
            phase_d = ttf_pkg::PhValTag;
          end
        end
      end
      ttf_pkg::PhValTag: begin
        case (byte_i)
          ttf_pkg::TagNil: begin
            kind_d = ttf_pkg::KindNil; emit = 1'b1; ev_ends = 1'b1;
          end
          ttf_pkg::TagSmallInt: begin
            kind_d = ttf_pkg::KindInt; phase_d = ttf_pkg::PhVSmall;
          end
          ttf_pkg::TagInt: begin
            kind_d = ttf_pkg::KindInt; cnt_d = 3'd0; word_d = 32'd0;
            phase_d = ttf_pkg::PhVInt;
          end
          ttf_pkg::TagBinary: begin
            kind_d = ttf_pkg::KindBin; cnt_d = 3'd0; word_d = 32'd0;
            phase_d = ttf_pkg::PhBinLen;
          end
          ttf_pkg::TagString: begin
            kind_d = ttf_pkg::KindList; cnt_d = 3'd0; word_d = 32'd0;
            phase_d = ttf_pkg::PhStrLen;
          end
          ttf_pkg::TagList: begin
            kind_d = ttf_pkg::KindList; cnt_d = 3'd0; word_d = 32'd0;
            phase_d = ttf_pkg::PhListLen;
          end
          default: begin
            emit = 1'b1; ev = ttf_pkg::EvErr; ev_err = ttf_pkg::ErrTag; ev_ends = 1'b1;
          end
        endcase
      end
      ttf_pkg::PhVSmall: begin
        emit = 1'b1; ev = ttf_pkg::EvInt; ev_data = {24'd0, byte_i}; ev_ends = 1'b1;
      end
      ttf_pkg::PhVInt: begin
        word_d = word_shift;
        if (cnt_inc >= 3'd4) begin
          cnt_d = 3'd0;
          emit = 1'b1; ev = ttf_pkg::EvInt; ev_data = word_shift; ev_ends = 1'b1;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      ttf_pkg::PhBinLen, ttf_pkg::PhStrLen, ttf_pkg::PhListLen: begin
        word_d = word_shift;
        if (cnt_inc >= ((phase_q == ttf_pkg::PhStrLen) ? 3'd2 : 3'd4)) begin
          cnt_d  = 3'd0;
          rem_d  = (phase_q == ttf_pkg::PhStrLen) ? len_str : len_word;
          elem_d = 32'd0;
          if (rem_d == '0) begin
            emit = 1'b1; ev = ttf_pkg::EvErr; ev_err = ttf_pkg::ErrZero; ev_ends = 1'b1;
          end else if (phase_q == ttf_pkg::PhBinLen) begin
            phase_d = ttf_pkg::PhBinData;
          end else if (phase_q == ttf_pkg::PhStrLen) begin
            phase_d = ttf_pkg::PhStrData;
          end else begin
            phase_d = ttf_pkg::PhLTag;
          end
        end else begin
          cnt_d = cnt_inc;
        end
      end
      ttf_pkg::PhBinData, ttf_pkg::PhStrData: begin
        elem_d  = elem_q + 32'd1;
        rem_d   = rem_dec;
        emit    = 1'b1;
        ev      = (phase_q == ttf_pkg::PhBinData) ? ttf_pkg::EvBlob : ttf_pkg::EvElem;
        ev_data = {24'd0, byte_i};
        ev_pos  = elem_q;
        ev_ends = rem_zero;
      end
      ttf_pkg::PhLTag: begin
        if (byte_i == ttf_pkg::TagSmallInt || byte_i == ttf_pkg::TagInt) begin
          wide_d  = (byte_i == ttf_pkg::TagInt);
          cnt_d   = 3'd0;
          word_d  = 32'd0;
          phase_d = ttf_pkg::PhLElem;
        end else begin
          emit = 1'b1; ev = ttf_pkg::EvErr; ev_err = ttf_pkg::ErrTag; ev_ends = 1'b1;
        end
      end
      ttf_pkg::PhLElem: begin
        word_d = word_shift;
        if (cnt_inc >= (wide_q ? 3'd4 : 3'd1)) begin
          cnt_d   = 3'd0;
          elem_d  = elem_q + 32'd1;
          rem_d   = rem_dec;
          phase_d = rem_zero ? ttf_pkg::PhLNil : ttf_pkg::PhLTag;
          emit    = 1'b1;
          ev      = ttf_pkg::EvElem;
          ev_data = word_shift;
          ev_pos  = elem_q;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      ttf_pkg::PhLNil: begin
        emit    = 1'b1;
        ev_ends = 1'b1;
        if (byte_i != ttf_pkg::TagNil) begin
          ev = ttf_pkg::EvErr; ev_err = ttf_pkg::ErrTag;
        end
      end
      default: begin
        emit = 1'b1; ev = ttf_pkg::EvErr; ev_err = ttf_pkg::ErrMagic; ev_ends = 1'b1;
      end
    endcase
    if (emit && ev_ends) begin
      phase_d = ttf_pkg::PhMagic;
    end
  end

  always_comb begin
    res_valid_o        = accept_i && emit;
    res_o.event_res    = ev;
    res_o.data         = ev_data;
    res_o.position     = ev_pos;
    res_o.arity        = arity_d;
    res_o.value_kind   = kind_d;
    res_o.error_code   = ev_err;
    res_o.ends_message = ev_ends;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ttf_pkg::PhMagic;
      cnt_q       <= 3'd0;
      word_q      <= 32'd0;
      rem_q       <= '0;
      elem_q      <= 32'd0;
      arity_q     <= 2'd0;
      kind_q      <= ttf_pkg::KindNil;
      wide_q      <= 1'b0;
      key_limit_q <= ttf_pkg::KeyLimitReset;
    end else begin
      if (cfg_we_i) begin
        key_limit_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        word_q  <= word_d;
        rem_q   <= rem_d;
        elem_q  <= elem_d;
        arity_q <= arity_d;
        kind_q  <= kind_d;
        wide_q  <= wide_d;
      end
    end
  end

endmodule

[rtl/ttf_out_reg.sv]
// ----------------------------------------------------------------------------
// Term format parser result register
// Holds one result until the downstream side takes it and tells the input
// side whether a new byte may be taken in this cycle.
// ----------------------------------------------------------------------------
module ttf_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  ttf_pkg::result_t res_i,
  input  logic             take_i,
  output logic             free_o,
  output logic             valid_o,
  output ttf_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  ttf_pkg::result_t res_q;

  assign free_o  = !valid_q || take_i;
  assign valid_d = free_o ? load_i : valid_q;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

[rtl/term_format_stream_parser_core.sv]
// ----------------------------------------------------------------------------
// Term format stream parser
// Parses magic, small tuple, binary key and optional value one byte a
// transfer and streams out key bytes, values, list elements and blob bytes.
// ----------------------------------------------------------------------------
// One byte is taken in every cycle unless the result register is full and stalled; its result,
// if any, appears on the master side in the next cycle from a single result register, and a
// new byte is taken whenever that register is empty or is being emptied in the same cycle.
// The rate is set by the one-step parse logic between the state registers and the result
// register: one byte per cycle while the master side is not stalling.
module term_format_stream_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,        // key_limit
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,     // byte_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,     // data, position, arity, error_code, zero fill
  output logic [4:0]  m_axis_tuser_o,     // event_res, value_kind
  output logic        m_axis_tlast_o      // ends_message
);

  logic             accept;
  logic             res_valid;
  logic             free;
  ttf_pkg::result_t res;
  ttf_pkg::result_t out_res;

  assign s_axis_tready_o = free;
  assign accept          = s_axis_tvalid_i && free;

  ttf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ttf_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .take_i  (m_axis_tready_i),
    .free_o  (free),
    .valid_o (m_axis_tvalid_o),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = {3'd0, out_res.error_code, out_res.arity,
                           out_res.position, out_res.data};
  assign m_axis_tuser_o = {out_res.value_kind, out_res.event_res};
  assign m_axis_tlast_o = out_res.ends_message;

endmodule

[rtl/ttf_checker.sv]
// ----------------------------------------------------------------------------
// Term format parser port checker
// Watches the ports of the parser top level for handshake and result coding slips.
// ----------------------------------------------------------------------------
module ttf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [71:0] m_axis_tdata_i,
  input logic [4:0]  m_axis_tuser_i,
  input logic        m_axis_tlast_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i)
      && $stable(m_axis_tlast_i))
    else $error("stalled result changed");

  a_err_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (m_axis_tuser_i[2:0] == ttf_pkg::EvErr) |->
      m_axis_tlast_i && (m_axis_tdata_i[68:66] != ttf_pkg::ErrNone))
    else $error("error result without close or code");

  a_code_only_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (m_axis_tuser_i[2:0] != ttf_pkg::EvErr) |->
      (m_axis_tdata_i[68:66] == ttf_pkg::ErrNone))
    else $error("error code on a non-error result");

  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (m_axis_tuser_i[2:0] == ttf_pkg::EvEnd) |->
      m_axis_tlast_i && (m_axis_tdata_i[63:0] == 64'd0))
    else $error("end result carries data or is not closing");

endmodule

bind term_format_stream_parser_core ttf_checker u_ttf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);

[tb/term_format_stream_parser_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Term format stream parser testbench
// Streams directed and random term messages, well-formed, broken and noise,
// into the parser under random idling on both sides. A built-in predictor
// tracks the parse state for every accepted byte, and each result transfer
// is checked field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module term_format_stream_parser_core_tb;
  import ttf_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned LongHold = 300;
  localparam int unsigned BytesPerRun = 55;
  localparam logic [31:0] LenMask = 32'hFFFF_FFFF >> (32 - LengthWidth);

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [4:0]  m_tuser;
  logic        m_tlast;

  term_format_stream_parser_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  logic [7:0]  tx_bytes[$];
  result_t     expected_events[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned pushed = 0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  phase_e      ph = PhMagic;
  logic [2:0]  nbytes = '0;
  logic [31:0] word = '0;
  logic [31:0] remain = '0;
  logic [31:0] elem_idx = '0;
  logic [1:0]  tup_arity = '0;
  kind_e       kind = KindNil;
  bit          wide = 1'b0;
  logic [7:0]  key_lim = KeyLimitReset;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic result_t make_res(event_e ev, logic [31:0] d, logic [31:0] pos,
                                       err_e err, logic ends);
    result_t r;
    r.event_res    = ev;
    r.data         = d;
    r.position     = pos;
    r.arity        = tup_arity;
    r.value_kind   = kind;
    r.error_code   = err;
    r.ends_message = ends;
    if (ends) ph = PhMagic;
    return r;
  endfunction

  function automatic bit gather(logic [7:0] b, int unsigned n);
    word = {word[23:0], b};
    nbytes = nbytes + 3'd1;
    if (nbytes >= n) begin
      nbytes = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void start_word(phase_e next);
    nbytes = '0;
    word = '0;
    ph = next;
  endfunction

  // Advances the parse state by one byte; returns 1 when the byte yields a result.
  function automatic bit parse_byte(logic [7:0] b, output result_t r);
    bit          shown;
    logic [31:0] pos;
    event_e      ev;
    int unsigned n;
    r = '0;
    case (ph)
      PhMagic: begin
        tup_arity = '0;
        kind = KindNil;
        if (b != MagicByte) begin
          r = make_res(EvErr, '0, '0, ErrMagic, 1'b1);
          return 1'b1;
        end
        ph = PhTuple;
      end
      PhTuple: begin
        if (b != TagSmallTuple) begin
          r = make_res(EvErr, '0, '0, ErrTuple, 1'b1);
          return 1'b1;
        end
        ph = PhArity;
      end
      PhArity: begin
        if (b > 8'd2) begin
          r = make_res(EvErr, '0, '0, ErrArity, 1'b1);
          return 1'b1;
        end
        tup_arity = b[1:0];
        if (b == 8'd0) begin
          r = make_res(EvEnd, '0, '0, ErrNone, 1'b1);
          return 1'b1;
        end
        ph = PhKeyTag;
      end
      PhKeyTag: begin
        if (b != TagBinary) begin
          r = make_res(EvErr, '0, '0, ErrTag, 1'b1);
          return 1'b1;
        end
        start_word(PhKeyLen);
      end
      PhKeyLen: begin
        if (!gather(b, 4)) return 1'b0;
        remain = word & LenMask;
        elem_idx = '0;
        if (remain != 0) begin
          ph = PhKeyData;
          return 1'b0;
        end
        if (tup_arity == 2'd1) begin
          r = make_res(EvEnd, '0, '0, ErrNone, 1'b1);
          return 1'b1;
        end
        ph = PhValTag;
      end
      PhKeyData: begin
        shown = elem_idx < {24'd0, key_lim};
        pos = elem_idx;
        elem_idx = elem_idx + 1;
        remain = remain - 1;
        if (remain == 0) begin
          if (tup_arity == 2'd1) begin
            if (shown) r = make_res(EvKey, {24'd0, b}, pos, ErrNone, 1'b1);
            else r = make_res(EvEnd, '0, '0, ErrNone, 1'b1);
            return 1'b1;
          end
          ph = PhValTag;
        end
        if (shown) begin
          r = make_res(EvKey, {24'd0, b}, pos, ErrNone, 1'b0);
          return 1'b1;
        end
      end
      PhValTag: begin
        case (b)
          TagNil: begin
            kind = KindNil;
            r = make_res(EvEnd, '0, '0, ErrNone, 1'b1);
            return 1'b1;
          end
          TagSmallInt: begin
            kind = KindInt;
            ph = PhVSmall;
          end
          TagInt: begin
            kind = KindInt;
            start_word(PhVInt);
          end
          TagBinary: begin
            kind = KindBin;
            start_word(PhBinLen);
          end
          TagString: begin
            kind = KindList;
            start_word(PhStrLen);
          end
          TagList: begin
            kind = KindList;
            start_word(PhListLen);
          end
          default: begin
            r = make_res(EvErr, '0, '0, ErrTag, 1'b1);
            return 1'b1;
          end
        endcase
      end
      PhVSmall: begin
        r = make_res(EvInt, {24'd0, b}, '0, ErrNone, 1'b1);
        return 1'b1;
      end
      PhVInt: begin
        if (!gather(b, 4)) return 1'b0;
        r = make_res(EvInt, word, '0, ErrNone, 1'b1);
        return 1'b1;
      end
      PhBinLen, PhStrLen, PhListLen: begin
        n = (ph == PhStrLen) ? 2 : 4;
        if (!gather(b, n)) return 1'b0;
        remain = word & LenMask;
        if (ph == PhStrLen) remain = remain & 32'h0000_FFFF;
        elem_idx = '0;
        if (remain == 0) begin
          r = make_res(EvErr, '0, '0, ErrZero, 1'b1);
          return 1'b1;
        end
        ph = (ph == PhBinLen) ? PhBinData : (ph == PhStrLen) ? PhStrData : PhLTag;
      end
      PhBinData, PhStrData: begin
        ev = (ph == PhBinData) ? EvBlob : EvElem;
        pos = elem_idx;
        elem_idx = elem_idx + 1;
        remain = remain - 1;
        r = make_res(ev, {24'd0, b}, pos, ErrNone, remain == 0);
        return 1'b1;
      end
      PhLTag: begin
        if (b == TagSmallInt) wide = 1'b0;
        else if (b == TagInt) wide = 1'b1;
        else begin
          r = make_res(EvErr, '0, '0, ErrTag, 1'b1);
          return 1'b1;
        end
        start_word(PhLElem);
      end
      PhLElem: begin
        pos = elem_idx;
        if (!gather(b, wide ? 4 : 1)) return 1'b0;
        elem_idx = elem_idx + 1;
        remain = remain - 1;
        ph = (remain == 0) ? PhLNil : PhLTag;
        r = make_res(EvElem, word, pos, ErrNone, 1'b0);
        return 1'b1;
      end
      PhLNil: begin
        if (b != TagNil) r = make_res(EvErr, '0, '0, ErrTag, 1'b1);
        else r = make_res(EvEnd, '0, '0, ErrNone, 1'b1);
        return 1'b1;
      end
      default: begin
        ph = PhMagic;
        r = make_res(EvErr, '0, '0, ErrMagic, 1'b1);
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Sender: one byte per transfer, a random number of idle cycles after each.
  always @(posedge clk_i) begin : drive_bytes
    result_t res;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        if (parse_byte(s_tdata, res)) expected_events.push_back(res);
      end
      if (!s_tvalid || s_tready) begin
        if (tx_wait != 0) begin
          s_tvalid <= 1'b0;
          tx_wait <= tx_wait - 1;
        end else if (tx_bytes.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= tx_bytes.pop_front();
          if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
          tx_wait <= draw_wait(tx_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls after each transfer, plus one long hold-off.
  always @(posedge clk_i) begin : accept_results
    int unsigned w;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_tready <= 1'b0;
      hold_left <= LongHold;
      hold_done <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      w = draw_wait(rx_calm);
      m_tready <= (w == 0);
      rx_wait <= w;
    end else if (rx_wait > 1) begin
      rx_wait <= rx_wait - 1;
    end else begin
      rx_wait <= 0;
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_events.size() == 0) begin
        $error("Unexpected result transfer with event_res %0d.", m_tuser[2:0]);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        compare_field("event_res", 32'(want.event_res), 32'(m_tuser[2:0]));
        compare_field("data", want.data, m_tdata[31:0]);
        compare_field("position", want.position, m_tdata[63:32]);
        compare_field("arity", 32'(want.arity), 32'(m_tdata[65:64]));
        compare_field("value_kind", 32'(want.value_kind), 32'(m_tuser[4:3]));
        compare_field("error_code", 32'(want.error_code), 32'(m_tdata[68:66]));
        compare_field("ends_message", 32'(want.ends_message), 32'(m_tlast));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void push_byte(logic [7:0] b);
    tx_bytes.push_back(b);
    pushed++;
  endfunction

  function automatic void push_word(logic [31:0] w);
    push_byte(w[31:24]);
    push_byte(w[23:16]);
    push_byte(w[15:8]);
    push_byte(w[7:0]);
  endfunction

  function automatic logic [7:0] pick_byte_except(logic [7:0] a, logic [7:0] b);
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == a || v == b);
    return v;
  endfunction

  function automatic logic [7:0] bad_value_tag();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255));
    while (v == TagNil || v == TagSmallInt || v == TagInt || v == TagBinary ||
           v == TagString || v == TagList);
    return v;
  endfunction

  function automatic void push_head(logic [7:0] ar);
    push_byte(MagicByte);
    push_byte(TagSmallTuple);
    push_byte(ar);
  endfunction

  function automatic void push_key(logic [31:0] n);
    push_byte(TagBinary);
    push_word(n);
    for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void push_small(logic [7:0] v);
    push_byte(TagSmallInt);
    push_byte(v);
  endfunction

  function automatic void push_int(logic [31:0] v);
    push_byte(TagInt);
    push_word(v);
  endfunction

  function automatic void push_blob(logic [7:0] tag, logic [31:0] n);
    push_byte(tag);
    if (tag == TagString) begin
      push_byte(n[15:8]);
      push_byte(n[7:0]);
    end else begin
      push_word(n);
    end
    for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void push_list(logic [31:0] n, int bad_at, bit bad_end);
    push_byte(TagList);
    push_word(n);
    if (n == 0) return;
    for (int i = 0; i < n; i++) begin
      if (i == bad_at) begin
        push_byte(pick_byte_except(TagSmallInt, TagInt));
        return;
      end
      if ($urandom_range(0, 1) == 1) push_int($urandom());
      else push_small(8'($urandom_range(0, 255)));
    end
    push_byte(bad_end ? pick_byte_except(TagNil, TagNil) : TagNil);
  endfunction

  function automatic void push_good();
    logic [7:0]  ar;
    logic [31:0] klen;
    ar = ($urandom_range(0, 9) == 0) ? 8'd0 : ($urandom_range(0, 3) == 0) ? 8'd1 : 8'd2;
    klen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 5);
    push_head(ar);
    if (ar != 0) push_key(klen);
    if (ar == 2) begin
      case ($urandom_range(0, 5))
        0: push_byte(TagNil);
        1: push_small(8'($urandom_range(0, 255)));
        2: push_int($urandom());
        3: push_blob(TagBinary, $urandom_range(1, 6));
        4: push_blob(TagString, $urandom_range(1, 6));
        default: push_list($urandom_range(1, 5), -1, 1'b0);
      endcase
    end
  endfunction

  // Broken messages stop at the offending byte so the parser resynchronizes
  // on the message that follows.
  function automatic void push_random_message();
    int unsigned sel;
    int unsigned n;
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      push_byte(pick_byte_except(MagicByte, MagicByte));
    end else if (sel < 20) begin
      n = $urandom_range(1, 4);
      case ($urandom_range(0, 8))
        0: begin
          push_byte(MagicByte);
          push_byte(pick_byte_except(TagSmallTuple, TagSmallTuple));
        end
        1: push_head(8'($urandom_range(3, 255)));
        2: begin
          push_head(8'($urandom_range(1, 2)));
          push_byte(pick_byte_except(TagBinary, TagBinary));
        end
        3: begin
          push_head(8'd2);
          push_key($urandom_range(0, 3));
          push_byte(bad_value_tag());
        end
        4: begin
          push_head(8'd2);
          push_key($urandom_range(0, 3));
          push_blob(TagBinary, 0);
        end
        5: begin
          push_head(8'd2);
          push_key($urandom_range(0, 3));
          push_blob(TagString, 0);
        end
        6: begin
          push_head(8'd2);
          push_key($urandom_range(0, 3));
          push_list(0, -1, 1'b0);
        end
        7: begin
          push_head(8'd2);
          push_key($urandom_range(0, 3));
          push_list(n, $urandom_range(0, n - 1), 1'b0);
        end
        default: begin
          push_head(8'd2);
          push_key($urandom_range(0, 3));
          push_list(n, -1, 1'b1);
        end
      endcase
    end else begin
      push_good();
    end
  endfunction

  task automatic drain();
    do @(negedge clk_i);
    while (tx_bytes.size() != 0 || s_tvalid || expected_events.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_key_limit(logic [7:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    key_lim = v;
    @(negedge clk_i);
  endtask

  task automatic random_run(int unsigned nbytes);
    int unsigned target;
    target = pushed + nbytes;
    while (pushed < target) push_random_message();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(MagicByte);
    push_byte(8'h00);
    push_head(8'd3);
    push_head(8'd0);
    push_head(8'd1);
    push_byte(TagSmallInt);
    push_head(8'd1);
    push_key(0);
    push_head(8'd1);
    push_key(3);
    push_head(8'd2);
    push_key(2);
    push_byte(TagNil);
    push_head(8'd2);
    push_key(1);
    push_small(8'hFF);
    push_head(8'd2);
    push_key(0);
    push_int(32'h8000_0000);
    push_head(8'd2);
    push_key(0);
    push_int(32'h7FFF_FFFF);
    push_head(8'd2);
    push_key(1);
    push_blob(TagBinary, 3);
    push_head(8'd2);
    push_key(1);
    push_blob(TagBinary, 0);
    push_head(8'd2);
    push_key(1);
    push_blob(TagString, 2);
    push_head(8'd2);
    push_key(0);
    push_blob(TagString, 0);
    push_head(8'd2);
    push_key(1);
    push_list(3, -1, 1'b0);
    push_head(8'd2);
    push_key(0);
    push_list(0, -1, 1'b0);
    push_head(8'd2);
    push_key(0);
    push_list(2, 1, 1'b0);
    push_head(8'd2);
    push_key(0);
    push_list(2, -1, 1'b1);
    push_head(8'd2);
    push_key(0);
    push_byte(bad_value_tag());
    push_head(8'd2);
    push_key(34);
    push_small(8'h00);
    drain();

    set_key_limit(8'd0);
    push_head(8'd1);
    push_key(2);
    push_head(8'd2);
    push_key(3);
    push_small(8'h5A);
    drain();

    set_key_limit(8'd255);
    push_head(8'd1);
    push_key(40);
    push_head(8'd2);
    push_key(40);
    push_int(32'hFFFF_FFFF);
    drain();

    set_key_limit(8'd3);
    hold_req <= 1'b1;
    random_run(BytesPerRun);
    drain();

    set_key_limit(8'($urandom_range(0, 255)));
    random_run(BytesPerRun);
    drain();

    set_key_limit(8'd1);
    random_run(BytesPerRun);
    drain();

    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[term_format_stream_parser_core.f]
rtl/ttf_pkg.sv
rtl/ttf_parser.sv
rtl/ttf_out_reg.sv
rtl/term_format_stream_parser_core.sv
rtl/ttf_checker.sv
tb/term_format_stream_parser_core_tb.sv
